@@ src/quantize_mode_window_filter_assert.svh @@
// Assertion macros used by the port-level checker file.
`ifndef QUANTIZE_MODE_WINDOW_FILTER_ASSERT_SVH
`define QUANTIZE_MODE_WINDOW_FILTER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define QMWF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define QMWF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ src/qmwf_pkg.sv @@
// Package with shared types and constants of the mode window filter.
`timescale 1ns / 1ps
package qmwf_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 11;
  localparam logic [CfgIdxW-1:0] RegImageWidth = 3'd0;
  localparam logic [CfgIdxW-1:0] RegThreshOne = 3'd1;
  localparam logic [CfgIdxW-1:0] RegThreshTwo = 3'd2;
  localparam logic [CfgIdxW-1:0] RegThreshThree = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLevelZero = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLevelOne = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLevelTwo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegLevelThree = 3'd7;
  localparam logic [11:0] RowCountMax = 12'd4095;

  // Front-to-back request: one window column (oc) to evaluate.
  typedef struct packed {
    logic [12:0] col;
    logic        row_end;
  } qmwf_job_t;
endpackage

@@ src/quantize_mode_window_filter.sv @@
// Top level of the quantize and mode window filter.
// Usage: s_axis carries one request per pixel: tdata = {frame_start, pixel},
// tuser = kind (0 pixel, 1 flush replaying the last real row). m_axis returns
// results: tdata = {level_index, level_value}, tlast marks the row end.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i, to be written only while idle;
// the user must keep to this, the block itself does not enforce it. Each request
// passes the front states accept, store read and store write (then emit while it
// hands out jobs) and is accepted only while the job register and the back are
// empty. A request that closes a window column hands one job per output column
// to the back, which scans the WindowSize x WindowSize taps one per cycle through
// the single read port of the line store; each result then passes the back states
// take, scan, decide (waiting for the last read) and output. A one-entry job
// register between front and back holds a job while the back is busy.
// Reset clears the counters and state; line store contents stay undefined.
// A stalled receiver holds the result and backs up into the front.
`timescale 1ns / 1ps
module quantize_mode_window_filter #(
  parameter int unsigned WindowSize = 5,
  parameter int unsigned MaxWidth = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // pixel[7:0], frame_start[8], zero fill
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // level_value[7:0], level_index[9:8], zero fill
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);
  import qmwf_pkg::*;
  localparam int unsigned SlotW = $clog2(WindowSize);
  localparam int unsigned AddrW = $clog2(WindowSize * MaxWidth);

  logic [10:0] width_q;
  logic [7:0] th1_q, th2_q, th3_q, lv0_q, lv1_q, lv2_q, lv3_q;
  logic [12:0] weff;
  logic job_v, job_r, qv_q, q_rdy, f_rdy;
  qmwf_job_t job, job_q;
  logic [SlotW-1:0] wslot;
  logic [11:0] rows;
  logic f_rd, b_rd, f_we;
  logic [AddrW-1:0] f_ra, b_ra, f_wa;
  logic [1:0] f_wd, rdata_q;
  logic [1:0] mem [WindowSize*MaxWidth];
  logic [7:0] lvv;
  logic [1:0] lvi;

  assign weff = (width_q == 11'd0) ? 13'd1 :
                (13'(width_q) > 13'(MaxWidth)) ? 13'(MaxWidth) : 13'(width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 11'd1024; th1_q <= 8'd63; th2_q <= 8'd127; th3_q <= 8'd191;
      lv0_q <= 8'd32; lv1_q <= 8'd96; lv2_q <= 8'd160; lv3_q <= 8'd224;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegImageWidth: width_q <= cfg_data_i;
        RegThreshOne: th1_q <= cfg_data_i[7:0];
        RegThreshTwo: th2_q <= cfg_data_i[7:0];
        RegThreshThree: th3_q <= cfg_data_i[7:0];
        RegLevelZero: lv0_q <= cfg_data_i[7:0];
        RegLevelOne: lv1_q <= cfg_data_i[7:0];
        RegLevelTwo: lv2_q <= cfg_data_i[7:0];
        RegLevelThree: lv3_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // front only proceeds once the back is idle, so store and counters are coherent
  assign q_rdy = !qv_q && job_r;
  assign s_axis_tready = f_rdy && q_rdy;
  qmwf_front #(.WindowSize(WindowSize), .MaxWidth(MaxWidth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid && q_rdy), .in_ready_o(f_rdy),
    .kind_i(s_axis_tuser), .pixel_i(s_axis_tdata[7:0]), .frame_start_i(s_axis_tdata[8]),
    .width_i(weff), .th1_i(th1_q), .th2_i(th2_q), .th3_i(th3_q),
    .job_valid_o(job_v), .job_ready_i(!qv_q), .job_o(job),
    .wslot_o(wslot), .rows_o(rows),
    .mem_rd_o(f_rd), .mem_raddr_o(f_ra), .mem_rdata_i(rdata_q),
    .mem_we_o(f_we), .mem_waddr_o(f_wa), .mem_wdata_o(f_wd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) qv_q <= 1'b0;
    else if (job_v && !qv_q) qv_q <= 1'b1;
    else if (qv_q && job_r) qv_q <= 1'b0;
  end
  always_ff @(posedge clk_i) if (job_v && !qv_q) job_q <= job;

  qmwf_back #(.WindowSize(WindowSize), .MaxWidth(MaxWidth)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(qv_q), .job_ready_o(job_r), .job_i(job_q),
    .wslot_i(wslot), .rows_i(rows), .width_i(weff),
    .lv0_i(lv0_q), .lv1_i(lv1_q), .lv2_i(lv2_q), .lv3_i(lv3_q),
    .mem_rd_o(b_rd), .mem_raddr_o(b_ra), .mem_rdata_i(rdata_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .level_value_o(lvv), .level_index_o(lvi), .row_end_o(m_axis_tlast)
  );
  assign m_axis_tdata = {6'd0, lvi, lvv};

  always_ff @(posedge clk_i) begin
    if (f_we) mem[f_wa] <= f_wd;
    if (f_rd) rdata_q <= mem[f_ra];
    else if (b_rd) rdata_q <= mem[b_ra];
  end
  logic unused;
  assign unused = |s_axis_tdata[15:9];
endmodule

@@ src/qmwf_front.sv @@
// Front: quantizes pixels, writes the line store, issues output column jobs.
`timescale 1ns / 1ps
module qmwf_front #(
  parameter int unsigned WindowSize = 5,
  parameter int unsigned MaxWidth = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [7:0]        pixel_i,
  input  logic              frame_start_i,
  input  logic [12:0]       width_i,
  input  logic [7:0]        th1_i,
  input  logic [7:0]        th2_i,
  input  logic [7:0]        th3_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output qmwf_pkg::qmwf_job_t job_o,
  output logic [$clog2(WindowSize)-1:0] wslot_o,
  output logic [11:0]       rows_o,
  // shared read port control
  output logic              mem_rd_o,
  output logic [$clog2(WindowSize*MaxWidth)-1:0] mem_raddr_o,
  input  logic [1:0]        mem_rdata_i,
  output logic              mem_we_o,
  output logic [$clog2(WindowSize*MaxWidth)-1:0] mem_waddr_o,
  output logic [1:0]        mem_wdata_o
);
  import qmwf_pkg::*;
  localparam int unsigned Half = (WindowSize - 1) / 2;
  localparam int unsigned SlotW = $clog2(WindowSize);
  localparam int unsigned AddrW = $clog2(WindowSize * MaxWidth);

  typedef enum logic [3:0] {
    StIdle = 4'b0001, StRead = 4'b0010, StWrite = 4'b0100, StEmit = 4'b1000
  } fst_e;

  fst_e st_q, st_d;
  logic [12:0] col_q, col_d, c_q, c_d, oc_q, oc_d, last_q, last_d;
  logic [11:0] rows_q, rows_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic kind_q, kind_d;
  logic [7:0] pix_q, pix_d;
  logic [1:0] qidx;
  logic [SlotW-1:0] prev_slot;
  logic [12:0] cin;
  logic [SlotW-1:0] ws_q;
  logic [11:0] rw_q;

  assign prev_slot = (slot_q == '0) ? SlotW'(WindowSize - 1) : slot_q - SlotW'(1);
  assign qidx = (pix_q <= th1_i) ? 2'd0 : (pix_q <= th2_i) ? 2'd1 :
                (pix_q <= th3_i) ? 2'd2 : 2'd3;
  assign cin = frame_start_i ? 13'd0 : col_q;

  always_comb begin
    st_d = st_q; col_d = col_q; c_d = c_q; oc_d = oc_q; last_d = last_q;
    rows_d = rows_q; slot_d = slot_q; kind_d = kind_q; pix_d = pix_q;
    in_ready_o = (st_q == StIdle);
    mem_rd_o = 1'b0; mem_we_o = 1'b0;
    mem_raddr_o = AddrW'(prev_slot * MaxWidth + c_q);
    mem_waddr_o = AddrW'(slot_q * MaxWidth + c_q);
    mem_wdata_o = qidx;
    job_valid_o = 1'b0;
    job_o.col = oc_q;
    job_o.row_end = (oc_q == width_i - 13'd1);
    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          if (frame_start_i) rows_d = '0;
          c_d = (cin > width_i - 13'd1) ? width_i - 13'd1 : cin;
          kind_d = kind_i; pix_d = pixel_i;
          st_d = StRead;
        end
      end
      StRead: begin
        mem_rd_o = kind_q && (rows_q != 12'd0);
        st_d = StWrite;
      end
      StWrite: begin
        mem_we_o = 1'b1;
        mem_wdata_o = !kind_q ? qidx : (rows_q == 12'd0) ? 2'd0 : mem_rdata_i;
        if (rows_q >= 12'(Half)) begin
          if (c_q == width_i - 13'd1) begin
            oc_d = (c_q >= 13'(Half)) ? c_q - 13'(Half) : 13'd0;
            last_d = c_q; st_d = StEmit;
          end else if (c_q >= 13'(Half)) begin
            oc_d = c_q - 13'(Half); last_d = oc_d; st_d = StEmit;
          end else st_d = StIdle;
        end else st_d = StIdle;
        if (st_d == StIdle) begin
          if (c_q == width_i - 13'd1) begin
            col_d = '0;
            if (rows_q < RowCountMax) rows_d = rows_q + 12'd1;
            slot_d = (slot_q == SlotW'(WindowSize - 1)) ? '0 : slot_q + SlotW'(1);
          end else col_d = c_q + 13'd1;
        end
      end
      StEmit: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          if (oc_q == last_q) begin
            st_d = StIdle;
            if (c_q == width_i - 13'd1) begin
              col_d = '0;
              if (rows_q < RowCountMax) rows_d = rows_q + 12'd1;
              slot_d = (slot_q == SlotW'(WindowSize - 1)) ? '0 : slot_q + SlotW'(1);
            end else col_d = c_q + 13'd1;
          end else oc_d = oc_q + 13'd1;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  // row/slot seen by the back are registered at the store write and held until the next one
  assign wslot_o = ws_q;
  assign rows_o = rw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; col_q <= '0; rows_q <= '0; slot_q <= '0;
    end else begin
      st_q <= st_d; col_q <= col_d; rows_q <= rows_d; slot_q <= slot_d;
    end
  end
  always_ff @(posedge clk_i) begin
    c_q <= c_d; oc_q <= oc_d; last_q <= last_d; kind_q <= kind_d;
    pix_q <= pix_d;
    if (st_q == StWrite) begin
      ws_q <= slot_q; rw_q <= rows_q;
    end
  end
endmodule

@@ src/qmwf_back.sv @@
// Back: counts levels over the window one tap a cycle and emits the mode.
`timescale 1ns / 1ps
module qmwf_back #(
  parameter int unsigned WindowSize = 5,
  parameter int unsigned MaxWidth = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  qmwf_pkg::qmwf_job_t job_i,
  input  logic [$clog2(WindowSize)-1:0] wslot_i,
  input  logic [11:0]       rows_i,
  input  logic [12:0]       width_i,
  input  logic [7:0]        lv0_i,
  input  logic [7:0]        lv1_i,
  input  logic [7:0]        lv2_i,
  input  logic [7:0]        lv3_i,
  output logic              mem_rd_o,
  output logic [$clog2(WindowSize*MaxWidth)-1:0] mem_raddr_o,
  input  logic [1:0]        mem_rdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        level_value_o,
  output logic [1:0]        level_index_o,
  output logic              row_end_o
);
  import qmwf_pkg::*;
  localparam int unsigned Half = (WindowSize - 1) / 2;
  localparam int unsigned SlotW = $clog2(WindowSize);
  localparam int unsigned SumW = SlotW + 1;
  localparam int unsigned AddrW = $clog2(WindowSize * MaxWidth);
  localparam int unsigned KW = $clog2(WindowSize + 1);
  localparam int unsigned FW = $clog2(WindowSize * WindowSize + 1);

  typedef enum logic [3:0] {
    StIdle = 4'b0001, StScan = 4'b0010, StDecide = 4'b0100, StOut = 4'b1000
  } bst_e;

  bst_e st_q, st_d;
  qmwf_job_t job_q, job_d;
  logic [KW-1:0] k_q, k_d, dx_q, dx_d;
  logic pend_q, pend_d;
  logic [FW-1:0] freq_q [4];
  logic [FW-1:0] freq_d [4];
  logic [1:0] win_q, win_d;
  logic [1:0] best;
  logic [11:0] back;
  logic [SumW-1:0] slot_sum;
  logic [SlotW-1:0] slot;
  logic [12:0] colw, col;
  logic last_tap;

  always_comb begin
    back = (12'(k_q) > rows_i) ? rows_i : 12'(k_q);
    // back never exceeds WindowSize-1, so one conditional subtract wraps the slot
    slot_sum = SumW'(wslot_i) + SumW'(WindowSize) - SumW'(back);
    slot = (slot_sum >= SumW'(WindowSize)) ? SlotW'(slot_sum - SumW'(WindowSize)) :
                                             SlotW'(slot_sum);
    colw = job_q.col + 13'(dx_q);
    col = (colw < 13'(Half)) ? 13'd0 : colw - 13'(Half);
    if (col > width_i - 13'd1) col = width_i - 13'd1;
    mem_raddr_o = AddrW'(slot * MaxWidth + col);
    last_tap = (k_q == KW'(WindowSize - 1)) && (dx_q == KW'(WindowSize - 1));
    best = 2'd0;
    for (int i = 1; i < 4; i++) if (freq_q[i] > freq_q[best]) best = 2'(i);
  end

  always_comb begin
    st_d = st_q; job_d = job_q; k_d = k_q; dx_d = dx_q; pend_d = 1'b0; win_d = win_q;
    for (int i = 0; i < 4; i++) freq_d[i] = freq_q[i];
    mem_rd_o = 1'b0;
    job_ready_o = (st_q == StIdle);
    if (pend_q) freq_d[mem_rdata_i] = freq_q[mem_rdata_i] + FW'(1);
    case (st_q)
      StIdle: if (job_valid_i) begin
        job_d = job_i; k_d = '0; dx_d = '0;
        for (int i = 0; i < 4; i++) freq_d[i] = '0;
        st_d = StScan;
      end
      StScan: begin
        mem_rd_o = 1'b1; pend_d = 1'b1;
        if (last_tap) st_d = StDecide;
        else if (dx_q == KW'(WindowSize - 1)) begin
          dx_d = '0; k_d = k_q + KW'(1);
        end else dx_d = dx_q + KW'(1);
      end
      StDecide: if (!pend_q) begin
        win_d = best; st_d = StOut;
      end
      StOut: if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign out_valid_o = (st_q == StOut);
  assign level_index_o = win_q;
  assign row_end_o = job_q.row_end;
  always_comb begin
    case (win_q)
      2'd0: level_value_o = lv0_i;
      2'd1: level_value_o = lv1_i;
      2'd2: level_value_o = lv2_i;
      default: level_value_o = lv3_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; pend_q <= 1'b0;
    end else begin
      st_q <= st_d; pend_q <= pend_d;
    end
  end
  always_ff @(posedge clk_i) begin
    job_q <= job_d; k_q <= k_d; dx_q <= dx_d; win_q <= win_d;
    for (int i = 0; i < 4; i++) freq_q[i] <= freq_d[i];
  end
endmodule

@@ src/qmwf_checker.sv @@
// Port-level checker for the mode window filter, bound to the top level.
`timescale 1ns / 1ps
`include "quantize_mode_window_filter_assert.svh"
module qmwf_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  `QMWF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `QMWF_ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[15:10] == 6'd0)
  `QMWF_ASSERT_NEXT(a_no_accept_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                    !s_axis_tready)
endmodule

bind quantize_mode_window_filter qmwf_port_checker u_checker (.*);

@@ dv/qmwf_checker.sv @@
// Checker for the mode window filter: predicts results and compares them.
`timescale 1ns / 1ps
module qmwf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // pixel[7:0], frame_start[8], zero fill
  input  logic        s_axis_tuser,   // kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // level_value[7:0], level_index[9:8], zero fill
  input  logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);
  import qmwf_pkg::*;

  localparam int Win = 5;
  localparam int Half = (Win - 1) / 2;
  localparam int MaxW = 1024;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] index;
    logic       row_end;
  } level_result_t;

  logic [10:0] width_q;
  logic [7:0]  thresh_q [3];
  logic [7:0]  level_q [4];
  logic [1:0]  line_store [Win*MaxW];
  int unsigned col_q, row_q, slot_q;
  level_result_t expected_q [$];

  function automatic int unsigned eff_width();
    if (width_q == 0) return 1;
    if (width_q > MaxW) return MaxW;
    return width_q;
  endfunction

  function automatic int unsigned slot_back(int unsigned k);
    return (slot_q + Win - (k % Win)) % Win;
  endfunction

  function automatic logic [1:0] quantize(logic [7:0] p);
    if (p <= thresh_q[0]) return 2'd0;
    if (p <= thresh_q[1]) return 2'd1;
    if (p <= thresh_q[2]) return 2'd2;
    return 2'd3;
  endfunction

  function automatic logic [1:0] window_mode(int unsigned oc, int unsigned w);
    int unsigned freq [4];
    int unsigned back, base, col;
    logic [1:0] best;
    freq = '{0, 0, 0, 0};
    for (int k = 0; k < Win; k++) begin
      back = (k > row_q) ? row_q : k;
      base = slot_back(back) * MaxW;
      for (int dx = 0; dx < Win; dx++) begin
        col = (oc + dx < Half) ? 0 : oc + dx - Half;
        if (col > w - 1) col = w - 1;
        freq[line_store[base+col]]++;
      end
    end
    best = 0;
    for (int i = 1; i < 4; i++) if (freq[i] > freq[best]) best = i[1:0];
    return best;
  endfunction

  task automatic predict_pixel(logic kind, logic [7:0] pix, logic fs);
    int unsigned w, c, first, last;
    logic [1:0] idx, m;
    w = eff_width();
    if (fs) begin
      col_q = 0;
      row_q = 0;
    end
    c = (col_q > w - 1) ? w - 1 : col_q;
    if (!kind) idx = quantize(pix);
    else if (row_q == 0) idx = 0;
    else idx = line_store[slot_back(1)*MaxW + c];
    line_store[slot_q*MaxW + c] = idx;
    if (row_q >= Half) begin
      if (c == w - 1) begin
        first = (c >= Half) ? c - Half : 0;
        last = c;
      end else if (c >= Half) begin
        first = c - Half;
        last = first;
      end else begin
        first = 1;
        last = 0;
      end
      for (int unsigned oc = first; oc <= last && first <= last; oc++) begin
        m = window_mode(oc, w);
        expected_q.push_back(level_result_t'{level_q[m], m, oc == w - 1});
      end
    end
    if (c == w - 1) begin
      col_q = 0;
      if (row_q < RowCountMax) row_q++;
      slot_q = (slot_q + 1) % Win;
    end else begin
      col_q = c + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    level_result_t got, exp_r;
    if (!rst_ni) begin
      width_q = 1024;
      thresh_q = '{63, 127, 191};
      level_q = '{32, 96, 160, 224};
      col_q = 0;
      row_q = 0;
      slot_q = 0;
      expected_q.delete();
      fail_count_o = 0;
      result_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[7:0], m_axis_tdata[9:8], m_axis_tlast};
        result_count_o++;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r || m_axis_tdata[15:10] !== 0) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected %p, actual %p", exp_r, got);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_pixel(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegImageWidth:  width_q = cfg_data_i;
          RegThreshOne:   thresh_q[0] = cfg_data_i[7:0];
          RegThreshTwo:   thresh_q[1] = cfg_data_i[7:0];
          RegThreshThree: thresh_q[2] = cfg_data_i[7:0];
          RegLevelZero:   level_q[0] = cfg_data_i[7:0];
          RegLevelOne:    level_q[1] = cfg_data_i[7:0];
          RegLevelTwo:    level_q[2] = cfg_data_i[7:0];
          default:        level_q[3] = cfg_data_i[7:0];
        endcase
      end
    end
    pending_o = expected_q.size();
  end
endmodule

@@ dv/tb_quantize_mode_window_filter.sv @@
// Testbench top: drives frames and configuration into the mode window filter.
`timescale 1ns / 1ps
module tb_quantize_mode_window_filter;
  import qmwf_pkg::*;

  localparam int DrainCycles = 60;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 0;   // pixel[7:0], frame_start[8], zero fill
  logic        s_axis_tuser = 0;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;       // level_value[7:0], level_index[9:8], zero fill
  logic        m_axis_tlast;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = 0;
  logic [10:0] cfg_data_i = 0;
  int          fail_count, pending, result_count;
  int          request_count = 0;
  int          hold_off = 0;
  bit          stim_done = 0;

  always #10 clk_i = ~clk_i;

  quantize_mode_window_filter u_dut (.*);

  qmwf_checker u_checker (
    .*,
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .result_count_o(result_count)
  );

  // Receiver: random wait before each result, plus an optional long hold-off.
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off > 0) begin
        m_axis_tready <= 0;
        hold_off--;
        @(negedge clk_i);
      end else begin
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
          m_axis_tready <= 0;
          repeat (gap) @(negedge clk_i);
        end
        m_axis_tready <= 1;
        @(posedge clk_i);
        while (!m_axis_tvalid) @(posedge clk_i);
        @(negedge clk_i);
      end
    end
  end

  task automatic send_pixel(logic kind, logic [7:0] pix, logic fs, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {7'd0, fs, pix};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    request_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    @(negedge clk_i);
  endtask

  task automatic set_levels(logic [7:0] t1, logic [7:0] t2, logic [7:0] t3, bit rnd_lv);
    write_reg(RegThreshOne, 11'(t1));
    write_reg(RegThreshTwo, 11'(t2));
    write_reg(RegThreshThree, 11'(t3));
    write_reg(RegLevelZero, 11'(rnd_lv ? $urandom_range(0, 255) : 0));
    write_reg(RegLevelOne, 11'(rnd_lv ? $urandom_range(0, 255) : 255));
    write_reg(RegLevelTwo, 11'(rnd_lv ? $urandom_range(0, 255) : 85));
    write_reg(RegLevelThree, 11'(rnd_lv ? $urandom_range(0, 255) : 170));
  endtask

  // One frame: rows of real pixels then flush rows; burst skips sender gaps.
  task automatic send_frame(int w, int rows, int flush_rows, bit burst);
    for (int r = 0; r < rows + flush_rows; r++)
      for (int c = 0; c < w; c++)
        send_pixel(r >= rows, 8'($urandom_range(0, 255)), r == 0 && c == 0, burst);
  endtask

  initial begin
    @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: width 1 with extreme pixels, flush at frame top.
    write_reg(RegImageWidth, 11'd1);
    set_levels(8'd0, 8'd127, 8'd254, 1'b0);
    send_pixel(1'b1, 8'hff, 1'b1);
    send_pixel(1'b0, 8'h00, 1'b0);
    send_pixel(1'b0, 8'hff, 1'b0);
    send_pixel(1'b0, 8'h80, 1'b0);
    send_pixel(1'b0, 8'h7f, 1'b0);
    send_pixel(1'b1, 8'h55, 1'b0);
    send_pixel(1'b1, 8'haa, 1'b0);
    send_pixel(1'b1, 8'h00, 1'b0);
    wait_idle();

    // Width 0 treated as one, then a small width-3 frame.
    write_reg(RegImageWidth, 11'd0);
    send_pixel(1'b0, 8'h01, 1'b1);
    send_pixel(1'b0, 8'hfe, 1'b0);
    send_pixel(1'b0, 8'h40, 1'b0);
    wait_idle();
    write_reg(RegImageWidth, 11'd3);
    send_frame(3, 3, 3, 1'b0);
    wait_idle();

    // Random frames over several settings; one with a long receiver stall.
    for (int f = 0; request_count < 170 || f < 5; f++) begin
      int w;
      w = (f % 5 == 4) ? $urandom_range(12, 16) : $urandom_range(1, 7);
      write_reg(RegImageWidth, 11'(w));
      if (f == 1) set_levels(8'd255, 8'd255, 8'd255, 1'b1);
      else if (f == 2) set_levels(8'd0, 8'd0, 8'd0, 1'b1);
      else set_levels(8'($urandom_range(0, 90)), 8'($urandom_range(80, 170)),
                      8'($urandom_range(160, 255)), 1'b1);
      if (f == 3) hold_off = 300;
      send_frame(w, $urandom_range(1, 5), $urandom_range(0, 3), f == 3);
      wait_idle();
    end

    // Oversized width clamps to the maximum: a single pixel at the frame start.
    write_reg(RegImageWidth, 11'h7ff);
    send_pixel(1'b0, 8'h10, 1'b1, 1'b1);
    wait_idle();
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0 && pending == 0) begin
      $display("Covered %0d requests and %0d results over widths 0..2047,", request_count,
               result_count);
      $display("extreme thresholds, flush rows and long output stalls.");
      $display("quantize_mode_window_filter test passed");
    end else begin
      $display("quantize_mode_window_filter test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("quantize_mode_window_filter test failed");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+src
src/qmwf_pkg.sv
src/qmwf_front.sv
src/qmwf_back.sv
src/quantize_mode_window_filter.sv
src/qmwf_checker.sv
dv/qmwf_checker.sv
dv/tb_quantize_mode_window_filter.sv
